// ----- hw/rtl/pstt_pkg.sv -----
// Shared types and constants for the PSI section table tracker.
// Used by the front, queue, back and top-level modules; depends on nothing.
package pstt_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int SIZE_BITS   = 20;
    localparam int SLOT_BITS   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int IN_BITS     = 60;   // packed input item width
    localparam int IN_BYTES    = 64;   // tdata width in bits, a whole number of bytes
    localparam int OUT_BITS    = 44;
    localparam int OUT_BYTES   = 48;

    localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

    typedef enum logic [2:0] {
        DISP_SEEK_DROP = 3'd0,
        DISP_PASS      = 3'd1,
        DISP_ACCEPT    = 3'd2,
        DISP_OUT_SEQ   = 3'd3,
        DISP_CRC_FAIL  = 3'd4,
        DISP_SHORT     = 3'd5,
        DISP_FULL      = 3'd6
    } t_disp;

    localparam logic [1:0] CFG_SEEK    = 2'd0;
    localparam logic [1:0] CFG_EACH    = 2'd1;
    localparam logic [1:0] CFG_HANDLER = 2'd2;
    localparam logic [1:0] CFG_SINK    = 2'd3;

    localparam logic [7:0] TID_PAT = 8'h00;
    localparam logic [7:0] TID_PMT = 8'h02;

    // Classified section handed from the front to the back.
    typedef struct packed {
        logic        track;     // run table tracking
        t_disp       disp;      // final disposition when not tracked
        logic        gev;
        logic [7:0]  tid;
        logic        syn;
        logic [15:0] ext;
        logic [4:0]  ver;
        logic [8:0]  cur;
        logic [8:0]  last;
        logic        crc;
        logic [11:0] len;
    } t_cmd;

    typedef struct packed {
        t_disp                disp;
        logic                 gev;
        logic                 fs;
        logic                 ff;
        logic                 fu;
        logic                 fr;
        logic                 fe;
        logic                 dlv;
        logic                 rcc;
        logic [SIZE_BITS-1:0] bytes;
        logic [4:0]           over;
        logic [7:0]           olast;
    } t_res;

endpackage

// ----- hw/rtl/pstt_front.sv -----
// Front part: decodes an input beat, applies seek and passthrough rules.
// Depends on pstt_pkg.
module pstt_front (
    input  logic                        i_seek,
    input  logic                        i_handler,
    input  logic                        i_sink,
    input  logic [pstt_pkg::IN_BITS-1:0] i_data,
    output pstt_pkg::t_cmd              o_cmd
);
    logic [7:0] tid;
    logic       routed;
    logic       listed;

    assign tid    = i_data[7:0];
    assign routed = (tid == 8'h74) || (tid >= 8'h3A && tid <= 8'h3E);
    assign listed = (tid == pstt_pkg::TID_PAT) || (tid == pstt_pkg::TID_PMT) ||
                    (tid == 8'h40) || (tid == 8'h42) || (tid == 8'h70) || (tid == 8'h73);

    always_comb begin
        o_cmd.tid  = tid;
        o_cmd.syn  = i_data[8];
        o_cmd.ext  = i_data[8] ? i_data[24:9] : 16'd0;
        o_cmd.ver  = i_data[29:25];
        o_cmd.cur  = {1'b0, i_data[38:31]} + 9'd1;
        o_cmd.last = {1'b0, i_data[46:39]} + 9'd1;
        o_cmd.crc  = i_data[47];
        o_cmd.len  = i_data[59:48];
        if (i_seek && tid != pstt_pkg::TID_PAT && tid != pstt_pkg::TID_PMT) begin
            o_cmd.track = 1'b0;
            o_cmd.disp  = pstt_pkg::DISP_SEEK_DROP;
            o_cmd.gev   = 1'b0;
        end else if (!i_handler) begin
            o_cmd.track = 1'b0;
            o_cmd.disp  = pstt_pkg::DISP_PASS;
            o_cmd.gev   = i_sink && !routed;
        end else begin
            o_cmd.track = 1'b1;
            o_cmd.disp  = pstt_pkg::DISP_ACCEPT;
            o_cmd.gev   = i_sink && listed;
        end
    end
endmodule

// ----- hw/rtl/pstt_queue.sv -----
// Two-entry queue of classified sections between front and back.
// Depends on pstt_pkg.
module pstt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pstt_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output pstt_pkg::t_cmd o_cmd
);
    pstt_pkg::t_cmd r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// ----- hw/rtl/pstt_back.sv -----
// Back part: slot search over cycles, table state update, result register.
// Depends on pstt_pkg.
module pstt_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_each,
    input  logic                           i_empty,
    input  pstt_pkg::t_cmd                 i_cmd,
    output logic                           o_pop,
    output logic                           o_tvalid,
    input  logic                           i_tready,
    output pstt_pkg::t_res                 o_res
);
    localparam int SB = pstt_pkg::SLOT_BITS;
    localparam int ZB = pstt_pkg::SIZE_BITS;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPD, ST_OUT} t_state;

    t_state r_state;
    logic [pstt_pkg::TABLE_SLOTS-1:0] r_valid;
    logic [7:0]  r_tid  [pstt_pkg::TABLE_SLOTS];
    logic [15:0] r_ext  [pstt_pkg::TABLE_SLOTS];
    logic [4:0]  r_ver  [pstt_pkg::TABLE_SLOTS];
    logic [7:0]  r_pver [pstt_pkg::TABLE_SLOTS];
    logic [8:0]  r_nexp [pstt_pkg::TABLE_SLOTS];
    logic [8:0]  r_lsec [pstt_pkg::TABLE_SLOTS];
    logic [pstt_pkg::TABLE_SLOTS-1:0] r_init, r_rep;
    logic [ZB-1:0] r_pend [pstt_pkg::TABLE_SLOTS];
    logic [ZB-1:0] r_size [pstt_pkg::TABLE_SLOTS];

    pstt_pkg::t_cmd r_cmd;
    logic [SB:0]  r_idx;
    logic         r_hit, r_free_ok, r_new;
    logic [SB-1:0] r_hit_s, r_free_s, r_s;

    // Slot read for the update step (fresh slot reads creation values).
    logic [4:0]  s_ver;  logic [7:0] s_pver; logic [8:0] s_nexp, s_lsec;
    logic        s_init, s_rep; logic [ZB-1:0] s_pend, s_size;
    always_comb begin
        if (r_new) begin
            s_ver = 5'd0; s_pver = 8'hFF; s_nexp = 9'd0; s_lsec = 9'd0;
            s_init = 1'b0; s_rep = 1'b0; s_pend = '0; s_size = '0;
        end else begin
            s_ver = r_ver[r_s]; s_pver = r_pver[r_s]; s_nexp = r_nexp[r_s];
            s_lsec = r_lsec[r_s]; s_init = r_init[r_s]; s_rep = r_rep[r_s];
            s_pend = r_pend[r_s]; s_size = r_size[r_s];
        end
    end

    // Update computation, following the per-section rules.
    logic [4:0] n_ver; logic [7:0] n_pver; logic [8:0] n_nexp, n_lsec;
    logic n_init, n_rep; logic [ZB-1:0] n_pend, n_size;
    pstt_pkg::t_res n_res;
    logic [11:0] dsize;
    logic        ok;
    logic [ZB:0] sum;
    always_comb begin
        n_ver = s_ver; n_pver = s_pver; n_nexp = s_nexp; n_lsec = s_lsec;
        n_init = s_init; n_rep = s_rep; n_pend = s_pend; n_size = s_size;
        n_res = '0;
        n_res.gev = r_cmd.gev;
        ok = 1'b0; dsize = 12'd0; sum = '0;
        if (r_cmd.syn) begin
            if (r_cmd.len < 12'd4) begin
                n_res.disp = pstt_pkg::DISP_SHORT;
            end else if (!r_cmd.crc) begin
                n_res.disp = pstt_pkg::DISP_CRC_FAIL;
            end else begin
                n_ver = r_cmd.ver;
                if (s_lsec != 9'd0 && s_nexp != 9'd0 && {3'd0, r_cmd.ver} != s_pver) begin
                    n_pend = '0;
                    n_nexp = 9'd0;
                end
                n_lsec = r_cmd.last;
                dsize  = (r_cmd.len >= 12'd12) ? r_cmd.len - 12'd12 : 12'd0;
                if (!i_each && n_nexp + 9'd1 != r_cmd.cur) begin
                    n_res.disp = pstt_pkg::DISP_OUT_SEQ;
                end else begin
                    ok = 1'b1;
                    n_nexp = r_cmd.cur;
                end
            end
        end else begin
            ok = 1'b1;
            dsize = (r_cmd.len >= 12'd3) ? r_cmd.len - 12'd3 : 12'd0;
        end
        if (ok) begin
            n_res.disp = pstt_pkg::DISP_ACCEPT;
            sum = {1'b0, n_pend} + (ZB+1)'(dsize);
            n_pend = sum[ZB] ? pstt_pkg::SIZE_MAX : sum[ZB-1:0];
            if (n_nexp == 9'd1) begin
                n_res.fs = 1'b1;
                n_rep  = (n_pver == {3'd0, n_ver});
                n_pver = {3'd0, n_ver};
            end
            if (n_init) begin
                n_res.fr = n_rep;
                n_res.fu = !n_rep;
            end else begin
                n_res.ff = 1'b1;
            end
            n_res.bytes = n_pend;
            if (n_lsec == n_nexp) begin
                n_res.fe = 1'b1;
                if (n_rep && n_size != n_pend) n_res.fu = 1'b1;
                n_size = n_pend;
                n_init = 1'b1;
                n_nexp = 9'd0;
                n_rep  = 1'b0;
            end
            n_res.over  = n_ver;
            n_res.olast = 8'(n_lsec - 9'd1);
            if (i_each || n_res.fe) begin
                n_res.dlv = 1'b1;
                n_pend = '0;
            end
        end else begin
            n_res.rcc = 1'b1;
            n_nexp = 9'd0;
        end
    end

    logic [SB-1:0] scan_s;
    logic          scan_match;
    assign scan_s     = r_idx[SB-1:0];
    assign scan_match = r_valid[scan_s] && r_tid[scan_s] == r_cmd.tid &&
                        r_ext[scan_s] == r_cmd.ext;

    assign o_pop    = (r_state == ST_IDLE) && !i_empty;
    assign o_tvalid = (r_state == ST_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_cmd <= i_cmd;
                        r_idx <= '0;
                        r_hit <= 1'b0;
                        r_free_ok <= 1'b0;
                        if (i_cmd.track) begin
                            r_state <= ST_SCAN;
                        end else begin
                            o_res      <= '0;
                            o_res.disp <= i_cmd.disp;
                            o_res.gev  <= i_cmd.gev;
                            r_state    <= ST_OUT;
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_idx == (SB+1)'(pstt_pkg::TABLE_SLOTS)) begin
                        if (r_hit) begin
                            r_s <= r_hit_s; r_new <= 1'b0; r_state <= ST_UPD;
                        end else if (r_free_ok) begin
                            r_s <= r_free_s; r_new <= 1'b1; r_state <= ST_UPD;
                        end else begin
                            o_res      <= '0;
                            o_res.disp <= pstt_pkg::DISP_FULL;
                            o_res.gev  <= r_cmd.gev;
                            r_state    <= ST_OUT;
                        end
                    end else begin
                        if (scan_match && !r_hit) begin
                            r_hit <= 1'b1; r_hit_s <= scan_s;
                        end
                        if (!r_valid[scan_s] && !r_free_ok) begin
                            r_free_ok <= 1'b1; r_free_s <= scan_s;
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_UPD: begin
                    r_valid[r_s] <= 1'b1;
                    r_tid[r_s]   <= r_cmd.tid;
                    r_ext[r_s]   <= r_cmd.ext;
                    r_ver[r_s]   <= n_ver;
                    r_pver[r_s]  <= n_pver;
                    r_nexp[r_s]  <= n_nexp;
                    r_lsec[r_s]  <= n_lsec;
                    r_init[r_s]  <= n_init;
                    r_rep[r_s]   <= n_rep;
                    r_pend[r_s]  <= n_pend;
                    r_size[r_s]  <= n_size;
                    o_res        <= n_res;
                    r_state      <= ST_OUT;
                end
                ST_OUT: begin
                    if (i_tready) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- hw/rtl/psi_section_table_tracker_core.sv -----
// Top level of the PSI section table tracker: config registers, front, queue, back.
// Depends on pstt_pkg, pstt_front, pstt_queue and pstt_back.
//
// Usage: each s_axis beat carries the decoded header of one completed PSI
// section; each m_axis beat carries one result for it, in order. The
// configuration channel (i_cfg_valid/o_cfg_ready, index and data bit 0)
// writes the four mode bits and is always ready; write only while idle.
// A tracked section leaves the queue, the key search then visits every slot in
// turn, and the back end picks the slot and updates it before the result
// shows; dropped and passthrough sections show theirs in the cycle after
// leaving the queue. The back end takes one section at a time and pops the
// next only after m_axis has taken the result, so the sequential slot search
// sets the throughput when tracking.
// A two-entry queue lets the input accept while the back end works or the
// result waits; when the receiver stalls, the result holds on m_axis and
// s_axis_tready falls once the queue is full.
// Reset clears all slot valid bits and sets the registers to their
// defaults (table handler present, everything else off); it takes effect
// at once, with no clearing pass.
module psi_section_table_tracker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // table identifier, syntax indicator, extension id, version, current/next,
    // section number, last section number, crc ok, section length, zero fill
    input  logic [pstt_pkg::IN_BYTES-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // disposition, general_event, flag_start, flag_found, flag_update,
    // flag_repeat, flag_end, deliver, reset_continuity, table_bytes,
    // out_version, out_last_index, zero fill
    output logic [pstt_pkg::OUT_BYTES-1:0] m_axis_tdata
);
    logic r_seek, r_each, r_handler, r_sink;
    pstt_pkg::t_cmd f_cmd, q_cmd;
    pstt_pkg::t_res res;
    logic q_full, q_empty, pop, push;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seek <= 1'b0; r_each <= 1'b0; r_handler <= 1'b1; r_sink <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pstt_pkg::CFG_SEEK:    r_seek    <= i_cfg_data;
                pstt_pkg::CFG_EACH:    r_each    <= i_cfg_data;
                pstt_pkg::CFG_HANDLER: r_handler <= i_cfg_data;
                pstt_pkg::CFG_SINK:    r_sink    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pstt_front u_front (
        .i_seek(r_seek), .i_handler(r_handler), .i_sink(r_sink),
        .i_data(s_axis_tdata[pstt_pkg::IN_BITS-1:0]), .o_cmd(f_cmd)
    );

    pstt_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_cmd(f_cmd),
        .o_full(q_full), .i_pop(pop), .o_empty(q_empty), .o_cmd(q_cmd)
    );

    pstt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_each(r_each), .i_empty(q_empty),
        .i_cmd(q_cmd), .o_pop(pop), .o_tvalid(m_axis_tvalid),
        .i_tready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {4'd0, res.olast, res.over, res.bytes, res.rcc, res.dlv,
                           res.fe, res.fr, res.fu, res.ff, res.fs, res.gev, res.disp};
endmodule

// ----- hw/rtl/pstt_checker.sv -----
// Port-level checker for the PSI section table tracker, bound to the top level.
// Depends only on the top level's ports and pstt_pkg.
module pstt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [pstt_pkg::OUT_BYTES-1:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= pstt_pkg::DISP_FULL)
        else $error("bad disposition");
    a_dlv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[2:0] == pstt_pkg::DISP_ACCEPT)
        else $error("deliver without acceptance");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result after reset");
    a_rdy: assert property (@(posedge i_clk) !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");
endmodule

bind psi_section_table_tracker_core pstt_checker u_pstt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// ----- tb/tb_psi_section_table_tracker_core.sv -----
// Self-checking testbench for psi_section_table_tracker_core.
// Holds its own table tracker model and compares every result beat against it;
// depends on pstt_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_psi_section_table_tracker_core;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = pstt_pkg::TABLE_SLOTS + 8;
    localparam int POOL_KEYS    = 6;

    localparam logic [7:0] TID_NIT_ACT = 8'h40;
    localparam logic [7:0] TID_SDT_ACT = 8'h42;
    localparam logic [7:0] TID_TDT     = 8'h70;
    localparam logic [7:0] TID_TOT     = 8'h73;
    localparam logic [7:0] TID_AIT     = 8'h74;
    localparam logic [7:0] TID_DSM_LO  = 8'h3A;
    localparam logic [7:0] TID_DSM_HI  = 8'h3E;

    typedef struct {
        logic [7:0]  tid;
        logic        syn;
        logic [15:0] ext;
        logic [4:0]  ver;
        logic        cn;
        logic [7:0]  sec;
        logic [7:0]  lst;
        logic        crc;
        logic [11:0] len;
    } t_sec_hdr;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [1:0]                     i_cfg_index;
    logic                           i_cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [pstt_pkg::IN_BYTES-1:0]  s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [pstt_pkg::OUT_BYTES-1:0] m_axis_tdata;

    psi_section_table_tracker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Tracker model state.
    logic        mode_seek, mode_each, mode_handler, mode_sink;
    logic        tbl_valid    [pstt_pkg::TABLE_SLOTS];
    logic [7:0]  tbl_tid      [pstt_pkg::TABLE_SLOTS];
    logic [15:0] tbl_ext      [pstt_pkg::TABLE_SLOTS];
    int          tbl_ver      [pstt_pkg::TABLE_SLOTS];
    int          tbl_prev_ver [pstt_pkg::TABLE_SLOTS];
    int          tbl_next     [pstt_pkg::TABLE_SLOTS];
    int          tbl_last     [pstt_pkg::TABLE_SLOTS];
    logic        tbl_init     [pstt_pkg::TABLE_SLOTS];
    logic        tbl_repeat   [pstt_pkg::TABLE_SLOTS];
    int          tbl_pending  [pstt_pkg::TABLE_SLOTS];
    int          tbl_size     [pstt_pkg::TABLE_SLOTS];

    pstt_pkg::t_res expected_results[$];
    int   mismatches;
    int   items_sent;
    int   results_seen;
    int   cycles;
    int   burst_left;
    int   stall_mode;

    logic [7:0]  pool_tid [POOL_KEYS];
    logic [15:0] pool_ext [POOL_KEYS];
    logic [4:0]  pool_ver [POOL_KEYS];

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = 1'b1;
            #5 i_clk = 1'b0;
        end
    end

    function automatic pstt_pkg::t_res track_section(input t_sec_hdr h);
        pstt_pkg::t_res r;
        logic [15:0] ext;
        int          cur, last, s, free_slot, dsize, body;
        logic        ok, routed;
        r = '0;
        r.disp = pstt_pkg::DISP_SEEK_DROP;
        ext = h.syn ? h.ext : 16'd0;
        cur = int'(h.sec) + 1;
        last = int'(h.lst) + 1;
        s = -1;
        free_slot = -1;
        ok = 1'b0;
        dsize = 0;
        if (mode_seek && h.tid != pstt_pkg::TID_PAT && h.tid != pstt_pkg::TID_PMT) begin
            return r;
        end
        if (!mode_handler) begin
            routed = (h.tid == TID_AIT) || (h.tid >= TID_DSM_LO && h.tid <= TID_DSM_HI);
            r.disp = pstt_pkg::DISP_PASS;
            r.gev = mode_sink && !routed;
            return r;
        end
        r.gev = mode_sink && (h.tid == pstt_pkg::TID_PAT || h.tid == pstt_pkg::TID_PMT ||
                h.tid == TID_NIT_ACT || h.tid == TID_SDT_ACT || h.tid == TID_TDT ||
                h.tid == TID_TOT);
        for (int i = 0; i < pstt_pkg::TABLE_SLOTS; i++) begin
            if (tbl_valid[i]) begin
                if (s < 0 && tbl_tid[i] == h.tid && tbl_ext[i] == ext) s = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (s < 0 && free_slot >= 0) begin
            s = free_slot;
            tbl_valid[s] = 1'b1;
            tbl_tid[s] = h.tid;
            tbl_ext[s] = ext;
            tbl_ver[s] = 0;
            tbl_prev_ver[s] = 255;
            tbl_next[s] = 0;
            tbl_last[s] = 0;
            tbl_init[s] = 1'b0;
            tbl_repeat[s] = 1'b0;
            tbl_pending[s] = 0;
            tbl_size[s] = 0;
        end
        if (s < 0) begin
            r.disp = pstt_pkg::DISP_FULL;
            return r;
        end
        if (h.syn) begin
            if (h.len < 4) begin
                r.disp = pstt_pkg::DISP_SHORT;
            end else if (!h.crc) begin
                r.disp = pstt_pkg::DISP_CRC_FAIL;
            end else begin
                body = int'(h.len) - 4;
                tbl_ver[s] = int'(h.ver);
                // A new version in the middle of a table throws the partial table away.
                if (tbl_last[s] != 0 && tbl_next[s] != 0 && tbl_ver[s] != tbl_prev_ver[s]) begin
                    tbl_pending[s] = 0;
                    tbl_next[s] = 0;
                end
                tbl_last[s] = last;
                dsize = (body >= 8) ? body - 8 : 0;
                if (!mode_each && tbl_next[s] + 1 != cur) begin
                    r.disp = pstt_pkg::DISP_OUT_SEQ;
                end else begin
                    ok = 1'b1;
                    tbl_next[s] = cur;
                end
            end
        end else begin
            ok = 1'b1;
            dsize = (h.len >= 3) ? int'(h.len) - 3 : 0;
        end
        if (!ok) begin
            r.rcc = 1'b1;
            tbl_next[s] = 0;
            return r;
        end
        r.disp = pstt_pkg::DISP_ACCEPT;
        tbl_pending[s] = tbl_pending[s] + dsize;
        if (tbl_pending[s] > int'(pstt_pkg::SIZE_MAX)) tbl_pending[s] = int'(pstt_pkg::SIZE_MAX);
        if (tbl_next[s] == 1) begin
            r.fs = 1'b1;
            tbl_repeat[s] = (tbl_prev_ver[s] == tbl_ver[s]);
            tbl_prev_ver[s] = tbl_ver[s];
        end
        if (tbl_init[s]) begin
            if (tbl_repeat[s]) r.fr = 1'b1;
            else r.fu = 1'b1;
        end else begin
            r.ff = 1'b1;
        end
        r.bytes = pstt_pkg::SIZE_BITS'(tbl_pending[s]);
        if (tbl_last[s] == tbl_next[s]) begin
            r.fe = 1'b1;
            if (tbl_repeat[s] && tbl_size[s] != tbl_pending[s]) r.fu = 1'b1;
            tbl_size[s] = tbl_pending[s];
            r.bytes = pstt_pkg::SIZE_BITS'(tbl_pending[s]);
            tbl_init[s] = 1'b1;
            tbl_next[s] = 0;
            tbl_repeat[s] = 1'b0;
        end
        r.over = tbl_ver[s][4:0];
        r.olast = 8'(tbl_last[s] - 1);
        if (mode_each || r.fe) begin
            r.dlv = 1'b1;
            tbl_pending[s] = 0;
        end
        return r;
    endfunction

    // Sends one section header; the sender works in bursts with gaps between them.
    task automatic send_section(input t_sec_hdr h);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, h.len, h.crc, h.lst, h.sec, h.cn, h.ver, h.ext, h.syn, h.tid};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(track_section(h));
        items_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] idx, input logic val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            pstt_pkg::CFG_SEEK:    mode_seek = val;
            pstt_pkg::CFG_EACH:    mode_each = val;
            pstt_pkg::CFG_HANDLER: mode_handler = val;
            default:               mode_sink = val;
        endcase
    endtask

    task automatic set_modes(input logic seek, input logic each, input logic handler,
                             input logic sink);
        write_mode(pstt_pkg::CFG_SEEK, seek);
        write_mode(pstt_pkg::CFG_EACH, each);
        write_mode(pstt_pkg::CFG_HANDLER, handler);
        write_mode(pstt_pkg::CFG_SINK, sink);
    endtask

    function automatic t_sec_hdr make_hdr(input logic [7:0] tid, input logic syn,
                                          input logic [15:0] ext, input logic [4:0] ver,
                                          input logic [7:0] sec, input logic [7:0] lst,
                                          input logic crc, input logic [11:0] len);
        t_sec_hdr h;
        h.tid = tid; h.syn = syn; h.ext = ext; h.ver = ver; h.cn = 1'b1;
        h.sec = sec; h.lst = lst; h.crc = crc; h.len = len;
        return h;
    endfunction

    function automatic t_sec_hdr noise_hdr();
        t_sec_hdr h;
        h.tid = 8'($urandom_range(0, 255)); h.syn = 1'($urandom_range(0, 1));
        h.ext = 16'($urandom_range(0, 65535)); h.ver = 5'($urandom_range(0, 31));
        h.cn = 1'($urandom_range(0, 1)); h.sec = 8'($urandom_range(0, 255));
        h.lst = 8'($urandom_range(0, 255)); h.crc = 1'($urandom_range(0, 1));
        h.len = 12'($urandom_range(0, 4095));
        return h;
    endfunction

    task automatic test_directed_tracking();
        set_modes(1'b0, 1'b0, 1'b1, 1'b1);
        send_section(make_hdr(pstt_pkg::TID_PAT, 1'b1, 16'h0000, 5'd0, 8'd0, 8'd0, 1'b1, 12'd4));
        send_section(make_hdr(pstt_pkg::TID_PAT, 1'b1, 16'h0000, 5'd0, 8'd0, 8'd0, 1'b1, 12'd3));
        send_section(make_hdr(pstt_pkg::TID_PAT, 1'b1, 16'h0000, 5'd0, 8'd0, 8'd0, 1'b0,
                              12'd40));
        // Two-section table, repeated, then repeated with a size change.
        send_section(make_hdr(pstt_pkg::TID_PMT, 1'b1, 16'hFFFF, 5'd31, 8'd0, 8'd1, 1'b1,
                              12'd4095));
        send_section(make_hdr(pstt_pkg::TID_PMT, 1'b1, 16'hFFFF, 5'd31, 8'd1, 8'd1, 1'b1,
                              12'd4095));
        send_section(make_hdr(pstt_pkg::TID_PMT, 1'b1, 16'hFFFF, 5'd31, 8'd0, 8'd1, 1'b1,
                              12'd4095));
        send_section(make_hdr(pstt_pkg::TID_PMT, 1'b1, 16'hFFFF, 5'd31, 8'd1, 8'd1, 1'b1,
                              12'd4095));
        send_section(make_hdr(pstt_pkg::TID_PMT, 1'b1, 16'hFFFF, 5'd31, 8'd0, 8'd1, 1'b1,
                              12'd100));
        send_section(make_hdr(pstt_pkg::TID_PMT, 1'b1, 16'hFFFF, 5'd31, 8'd1, 8'd1, 1'b1,
                              12'd12));
        // Version change halfway through a table.
        send_section(make_hdr(pstt_pkg::TID_PMT, 1'b1, 16'hFFFF, 5'd3, 8'd0, 8'd1, 1'b1,
                              12'd50));
        send_section(make_hdr(pstt_pkg::TID_PMT, 1'b1, 16'hFFFF, 5'd4, 8'd1, 8'd1, 1'b1,
                              12'd50));
        send_section(make_hdr(pstt_pkg::TID_PMT, 1'b1, 16'hFFFF, 5'd4, 8'd1, 8'd1, 1'b1,
                              12'd50));
        send_section(make_hdr(8'hFF, 1'b1, 16'h0000, 5'd0, 8'd255, 8'd255, 1'b1, 12'd4095));
        send_section(make_hdr(8'hFF, 1'b1, 16'h0000, 5'd0, 8'd0, 8'd255, 1'b1, 12'd0));
        // No syntax indicator: extension ignored, short length clamped.
        send_section(make_hdr(TID_TDT, 1'b0, 16'hFFFF, 5'd31, 8'd255, 8'd0, 1'b0, 12'd2));
        send_section(make_hdr(TID_TDT, 1'b0, 16'h1234, 5'd0, 8'd0, 8'd0, 1'b1, 12'd4095));
        write_mode(pstt_pkg::CFG_EACH, 1'b1);
        send_section(make_hdr(pstt_pkg::TID_PMT, 1'b1, 16'hFFFF, 5'd7, 8'd2, 8'd3, 1'b1,
                              12'd30));
        send_section(make_hdr(pstt_pkg::TID_PMT, 1'b1, 16'hFFFF, 5'd7, 8'd3, 8'd3, 1'b1,
                              12'd30));
    endtask

    task automatic test_passthrough_and_seek();
        set_modes(1'b0, 1'b0, 1'b0, 1'b1);
        send_section(make_hdr(TID_AIT, 1'b1, 16'h0001, 5'd0, 8'd0, 8'd0, 1'b1, 12'd20));
        send_section(make_hdr(TID_DSM_LO, 1'b1, 16'h0001, 5'd0, 8'd0, 8'd0, 1'b1, 12'd20));
        send_section(make_hdr(TID_DSM_HI, 1'b0, 16'h0001, 5'd0, 8'd0, 8'd0, 1'b1, 12'd20));
        send_section(make_hdr(8'h39, 1'b1, 16'h0001, 5'd0, 8'd0, 8'd0, 1'b0, 12'd0));
        send_section(make_hdr(8'h3F, 1'b1, 16'h0001, 5'd0, 8'd0, 8'd0, 1'b1, 12'd20));
        set_modes(1'b1, 1'b0, 1'b1, 1'b1);
        send_section(make_hdr(8'h01, 1'b1, 16'h0000, 5'd0, 8'd0, 8'd0, 1'b1, 12'd20));
        send_section(make_hdr(pstt_pkg::TID_PAT, 1'b1, 16'h0000, 5'd0, 8'd0, 8'd0, 1'b1,
                              12'd20));
        send_section(make_hdr(pstt_pkg::TID_PMT, 1'b1, 16'h0002, 5'd0, 8'd0, 8'd0, 1'b1,
                              12'd20));
    endtask

    // Well-formed tables over a small key pool, mixed with broken and random sections.
    task automatic test_random_tables();
        t_sec_hdr h;
        int       k, n, roll;
        for (int i = 0; i < POOL_KEYS; i++) begin
            case (i)
                0:       pool_tid[i] = pstt_pkg::TID_PAT;
                1:       pool_tid[i] = pstt_pkg::TID_PMT;
                2:       pool_tid[i] = TID_NIT_ACT;
                3:       pool_tid[i] = TID_SDT_ACT;
                4:       pool_tid[i] = TID_TOT;
                default: pool_tid[i] = 8'($urandom_range(128, 255));
            endcase
            pool_ext[i] = 16'($urandom_range(0, 65535));
            pool_ver[i] = 5'($urandom_range(0, 31));
        end
        for (int p = 0; p < 10; p++) begin
            set_modes(p == 4 || p == 9, 1'(p % 2), p != 6, 1'((p / 2) % 2));
            while (items_sent < 40 + (p + 1) * 150) begin
                roll = $urandom_range(0, 99);
                if (roll < 10 || !mode_handler || mode_seek && roll < 40) begin
                    h = noise_hdr();
                    // Under tracking, most noise stays on pool keys so the store does not fill early.
                    if (mode_handler && !mode_seek && roll >= 3) begin
                        k = $urandom_range(0, POOL_KEYS - 1);
                        h.tid = pool_tid[k];
                        h.ext = pool_ext[k];
                    end
                    send_section(h);
                end else begin
                    k = $urandom_range(0, POOL_KEYS - 1);
                    if ($urandom_range(0, 2) == 0) pool_ver[k] = 5'($urandom_range(0, 31));
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
                    for (int s = 0; s <= n; s++) begin
                        if ($urandom_range(0, 49) == 0) continue;
                        h = make_hdr(pool_tid[k], 1'b1, pool_ext[k], pool_ver[k], 8'(s), 8'(n),
                                     $urandom_range(0, 29) != 0, 12'($urandom_range(4, 300)));
                        h.cn = 1'($urandom_range(0, 1));
                        if ($urandom_range(0, 19) == 0) h.len = 12'($urandom_range(3000, 4095));
                        send_section(h);
                    end
                end
            end
        end
    endtask

    task automatic test_store_full();
        set_modes(1'b0, 1'b0, 1'b1, 1'b1);
        repeat (24) begin
            send_section(make_hdr(8'($urandom_range(0, 255)), 1'b1,
                                  16'($urandom_range(0, 65535)),
                                  5'd1, 8'd0, 8'd0, 1'b1, 12'd16));
        end
        send_section(make_hdr(pstt_pkg::TID_PAT, 1'b1, 16'hBEEF, 5'd1, 8'd0, 8'd0, 1'b1,
                              12'd16));
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        pstt_pkg::t_res act, exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            act.disp  = pstt_pkg::t_disp'(m_axis_tdata[2:0]);
            act.gev   = m_axis_tdata[3];
            act.fs    = m_axis_tdata[4];
            act.ff    = m_axis_tdata[5];
            act.fu    = m_axis_tdata[6];
            act.fr    = m_axis_tdata[7];
            act.fe    = m_axis_tdata[8];
            act.dlv   = m_axis_tdata[9];
            act.rcc   = m_axis_tdata[10];
            act.bytes = m_axis_tdata[30:11];
            act.over  = m_axis_tdata[35:31];
            act.olast = m_axis_tdata[43:36];
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected result beat %h", m_axis_tdata);
            end else begin
                exp_r = expected_results.pop_front();
                if (act !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: result %0d expected disp=%0d gev=%b s/f/u/r/e=%b%b%b%b%b",
                                 results_seen, exp_r.disp, exp_r.gev, exp_r.fs, exp_r.ff,
                                 exp_r.fu, exp_r.fr, exp_r.fe);
                        $display("       dlv=%b rcc=%b bytes=%0d ver=%0d last=%0d", exp_r.dlv,
                                 exp_r.rcc, exp_r.bytes, exp_r.over, exp_r.olast);
                        $display("       actual disp=%0d gev=%b s/f/u/r/e=%b%b%b%b%b", act.disp,
                                 act.gev, act.fs, act.ff, act.fu, act.fr, act.fe);
                        $display("       dlv=%b rcc=%b bytes=%0d ver=%0d last=%0d", act.dlv,
                                 act.rcc, act.bytes, act.over, act.olast);
                    end
                end
            end
        end
    end

    // Receiver stalls on its own pattern, with stall-free stretches.
    always @(posedge i_clk) begin
        if (cycles % 300 == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = pstt_pkg::CFG_SEEK;
        i_cfg_data    = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b1;
        mode_seek = 1'b0; mode_each = 1'b0; mode_handler = 1'b1; mode_sink = 1'b0;
        for (int i = 0; i < pstt_pkg::TABLE_SLOTS; i++) tbl_valid[i] = 1'b0;
        mismatches = 0; items_sent = 0; results_seen = 0; cycles = 0;
        burst_left = 0; stall_mode = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_tracking();
        test_passthrough_and_seek();
        test_random_tables();
        test_store_full();
        wait_idle();
        $display("Sent %0d section headers over ten mode settings and checked %0d results,",
                 items_sent, results_seen);
        $display("including repeats, version changes, broken sequences and a full table store.");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
